>>> rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants, request types and helper functions of the odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_CM_PER_COUNT        = 2'd0;
  localparam logic [1:0] CFG_INVERSE_TRACK_WIDTH = 2'd1;

  localparam logic [15:0] CM_PER_COUNT_RST        = 16'd5433;
  localparam logic [15:0] INVERSE_TRACK_WIDTH_RST = 16'd2913;

  // angles in Q30 radians
  localparam logic signed [39:0] TWO_PI_Q30  = 40'sd6746518852;
  localparam logic signed [34:0] PI_Q30      = 35'sd3373259426;
  localparam logic signed [34:0] HALF_PI_Q30 = 35'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [4:0]         CORDIC_LAST = 5'd29;

  // bearing in Q16 radians
  localparam logic [24:0] TWO_PI_ANG    = 25'd411775;
  localparam logic signed [25:0] BRG_BIAS = 26'sd13176800; // 32 turns
  localparam logic signed [67:0] TURN_LIMIT = 68'sd8388608; // 128 rad

  typedef struct packed {
    logic               start;
    logic signed [33:0] a;
    logic signed [33:0] b;
  } mul_req_t;

  typedef struct packed {
    logic               start;
    logic signed [33:0] num;
    logic signed [37:0] den;
  } div_req_t;

  typedef struct packed {
    logic               start;
    logic signed [38:0] angle;
  } cor_req_t;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837830;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
    logic signed [31:0] r;
    if (v > 68'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -68'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/differential_drive_odometry.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Dead-reckoning pose update from absolute wheel encoder counts.
// ----------------------------------------------------------------------------
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------
// input    | in_valid/in_ready    | left_count, right_count
// output   | out_valid/out_ready  | x_position, y_position, heading
// config   | cfg_valid/cfg_ready  | cfg_index, cfg_data
//
// one transaction at a time
// the serial multiplier runs five products straight and six turning, the cordic one run
// straight and two turning, the divider one run turning, then comes the bearing wrap
// the first sample after reset only latches the counts and passes through S_OUT to the output
// reset clears the pose, the previous counts and loads the default registers
// a finished pose waits in the output register while the next input is taken
// ----------------------------------------------------------------------------
module differential_drive_odometry (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] left_count_i,
  input  logic signed [31:0] right_count_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] x_position_o,
  output logic signed [31:0] y_position_o,
  output logic [18:0]        heading_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LD    = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_TURN  = 4'd3;
  localparam logic [3:0] S_ANG   = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_CHORD = 4'd6;
  localparam logic [3:0] S_MX    = 4'd7;
  localparam logic [3:0] S_MY    = 4'd8;
  localparam logic [3:0] S_BRD   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  // control state
  logic [3:0]          state_q, state_d;
  logic                primed_q, primed_d;
  logic                pass_q, pass_d;
  logic [2:0]          k_q, k_d;
  logic                out_valid_q, out_valid_d;
  logic [15:0]         cpc_q, cpc_d;
  logic [15:0]         itw_q, itw_d;
  logic [31:0]         prev_l_q, prev_l_d;
  logic [31:0]         prev_r_q, prev_r_d;
  logic signed [31:0]  x_q, x_d;
  logic signed [31:0]  y_q, y_d;
  logic [18:0]         brg_q, brg_d;
  ddo_pkg::mul_req_t   mul_req_q, mul_req_d;
  ddo_pkg::div_req_t   div_req_q, div_req_d;
  ddo_pkg::cor_req_t   cor_req_q, cor_req_d;

  // working values
  logic [31:0]         dr_q, dr_d;
  logic signed [31:0]  ld_q, ld_d;
  logic signed [33:0]  mean_q, mean_d;
  logic signed [24:0]  turn_q, turn_d;
  logic signed [33:0]  chord_q, chord_d;
  logic signed [33:0]  cos_q, cos_d;
  logic [24:0]         bv_q, bv_d;
  logic signed [31:0]  ox_q, ox_d;
  logic signed [31:0]  oy_q, oy_d;
  logic [18:0]         oh_q, oh_d;

  logic               mul_done;
  logic signed [67:0] prod;
  logic               div_done;
  logic signed [32:0] ratio;
  logic               cor_done;
  logic signed [33:0] cor_sin;
  logic signed [33:0] cor_cos;

  logic               in_fire;
  logic               out_free;
  logic [31:0]        dl;
  logic signed [67:0] r8;
  logic signed [67:0] r30;
  logic signed [31:0] rd;
  logic signed [34:0] ld_rd_sum;
  logic signed [67:0] turn_cl;
  logic signed [38:0] h;
  logic signed [38:0] dir;
  logic signed [25:0] bsum;
  logic [24:0]        tpk;
  logic [24:0]        bv_red;

  ddo_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req_q),
    .done_o (mul_done),
    .prod_o (prod)
  );

  ddo_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .done_o (div_done),
    .quot_o (ratio)
  );

  ddo_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cor_req_q),
    .done_o (cor_done),
    .sin_o  (cor_sin),
    .cos_o  (cor_cos)
  );

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;

  assign dl        = left_count_i - prev_l_q;
  assign r8        = (prod + 68'sd128) >>> 8;
  assign r30       = (prod + (68'sd1 <<< 29)) >>> 30;
  assign rd        = ddo_pkg::sat32(r8);
  assign ld_rd_sum = 35'(ld_q) + 35'(rd) + 35'sd1;
  assign h         = 39'(turn_q) <<< 13;
  assign dir       = $signed({6'b000000, brg_q, 14'd0});
  assign bsum      = $signed({7'b0000000, brg_q}) + 26'(turn_q) + ddo_pkg::BRG_BIAS;
  assign tpk       = ddo_pkg::TWO_PI_ANG << k_q;
  assign bv_red    = (bv_q >= tpk) ? bv_q - tpk : bv_q;

  always_comb begin
    turn_cl = r8;
    if (r8 > ddo_pkg::TURN_LIMIT) begin
      turn_cl = ddo_pkg::TURN_LIMIT;
    end else if (r8 < -ddo_pkg::TURN_LIMIT) begin
      turn_cl = -ddo_pkg::TURN_LIMIT;
    end
  end

  always_comb begin
    state_d     = state_q;
    primed_d    = primed_q;
    pass_d      = pass_q;
    k_d         = k_q;
    out_valid_d = out_valid_q;
    cpc_d       = cpc_q;
    itw_d       = itw_q;
    prev_l_d    = prev_l_q;
    prev_r_d    = prev_r_q;
    x_d         = x_q;
    y_d         = y_q;
    brg_d       = brg_q;
    mul_req_d   = mul_req_q;
    div_req_d   = div_req_q;
    cor_req_d   = cor_req_q;
    mul_req_d.start = 1'b0;
    div_req_d.start = 1'b0;
    cor_req_d.start = 1'b0;
    dr_d    = dr_q;
    ld_d    = ld_q;
    mean_d  = mean_q;
    turn_d  = turn_q;
    chord_d = chord_q;
    cos_d   = cos_q;
    bv_d    = bv_q;
    ox_d    = ox_q;
    oy_d    = oy_q;
    oh_d    = oh_q;

    if (cfg_valid_i) begin
      case (cfg_index_i)
        ddo_pkg::CFG_CM_PER_COUNT:        cpc_d = cfg_data_i;
        ddo_pkg::CFG_INVERSE_TRACK_WIDTH: itw_d = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          prev_l_d = left_count_i;
          prev_r_d = right_count_i;
          if (!primed_q) begin
            primed_d = 1'b1;
            state_d  = S_OUT;
          end else begin
            dr_d        = right_count_i - prev_r_q;
            mul_req_d.a = 34'($signed(dl));
            mul_req_d.b = 34'(cpc_q);
            mul_req_d.start = 1'b1;
            state_d     = S_LD;
          end
        end
      end
      S_LD: begin
        if (mul_done) begin
          ld_d        = ddo_pkg::sat32(r8);
          mul_req_d.a = 34'($signed(dr_q));
          mul_req_d.b = 34'(cpc_q);
          mul_req_d.start = 1'b1;
          state_d     = S_RD;
        end
      end
      S_RD: begin
        if (mul_done) begin
          mean_d      = 34'(ld_rd_sum >>> 1);
          mul_req_d.a = 34'(ld_q) - 34'(rd);
          mul_req_d.b = 34'(itw_q);
          mul_req_d.start = 1'b1;
          state_d     = S_TURN;
        end
      end
      S_TURN: begin
        if (mul_done) begin
          turn_d = turn_cl[24:0];
          cor_req_d.start = 1'b1;
          state_d = S_ANG;
          if (turn_cl == 68'sd0) begin
            chord_d         = mean_q;
            cor_req_d.angle = dir;
            pass_d          = 1'b1;
          end else begin
            cor_req_d.angle = 39'($signed(turn_cl[24:0])) <<< 13;
            pass_d          = 1'b0;
          end
        end
      end
      S_ANG: begin
        if (cor_done) begin
          if (!pass_q) begin
            div_req_d.num   = cor_sin;
            div_req_d.den   = 38'(h);
            div_req_d.start = 1'b1;
            state_d         = S_DIV;
          end else begin
            cos_d           = cor_cos;
            mul_req_d.a     = chord_q;
            mul_req_d.b     = cor_sin;
            mul_req_d.start = 1'b1;
            state_d         = S_MX;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          mul_req_d.a     = mean_q;
          mul_req_d.b     = 34'(ratio);
          mul_req_d.start = 1'b1;
          state_d         = S_CHORD;
        end
      end
      S_CHORD: begin
        if (mul_done) begin
          // arc taken as its chord along the mid-turn direction
          chord_d         = r30[33:0];
          cor_req_d.angle = dir + h;
          cor_req_d.start = 1'b1;
          pass_d          = 1'b1;
          state_d         = S_ANG;
        end
      end
      S_MX: begin
        if (mul_done) begin
          x_d             = ddo_pkg::sat32(68'(x_q) + r30);
          mul_req_d.a     = chord_q;
          mul_req_d.b     = cos_q;
          mul_req_d.start = 1'b1;
          state_d         = S_MY;
        end
      end
      S_MY: begin
        if (mul_done) begin
          y_d     = ddo_pkg::sat32(68'(y_q) + r30);
          bv_d    = bsum[24:0];
          k_d     = 3'd5;
          state_d = S_BRD;
        end
      end
      S_BRD: begin
        // bearing wrap by compare and subtract of shifted full turns
        bv_d = bv_red;
        if (k_q == 3'd0) begin
          brg_d   = bv_red[18:0];
          state_d = S_OUT;
        end else begin
          k_d = k_q - 3'd1;
        end
      end
      S_OUT: begin
        if (out_free) begin
          ox_d        = x_q;
          oy_d        = y_q;
          oh_d        = brg_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      primed_q    <= 1'b0;
      pass_q      <= 1'b0;
      k_q         <= 3'd0;
      out_valid_q <= 1'b0;
      cpc_q       <= ddo_pkg::CM_PER_COUNT_RST;
      itw_q       <= ddo_pkg::INVERSE_TRACK_WIDTH_RST;
      prev_l_q    <= '0;
      prev_r_q    <= '0;
      x_q         <= '0;
      y_q         <= '0;
      brg_q       <= '0;
      mul_req_q   <= '0;
      div_req_q   <= '0;
      cor_req_q   <= '0;
    end else begin
      state_q     <= state_d;
      primed_q    <= primed_d;
      pass_q      <= pass_d;
      k_q         <= k_d;
      out_valid_q <= out_valid_d;
      cpc_q       <= cpc_d;
      itw_q       <= itw_d;
      prev_l_q    <= prev_l_d;
      prev_r_q    <= prev_r_d;
      x_q         <= x_d;
      y_q         <= y_d;
      brg_q       <= brg_d;
      mul_req_q   <= mul_req_d;
      div_req_q   <= div_req_d;
      cor_req_q   <= cor_req_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dr_q    <= dr_d;
    ld_q    <= ld_d;
    mean_q  <= mean_d;
    turn_q  <= turn_d;
    chord_q <= chord_d;
    cos_q   <= cos_d;
    bv_q    <= bv_d;
    ox_q    <= ox_d;
    oy_q    <= oy_d;
    oh_q    <= oh_d;
  end

  assign out_valid_o  = out_valid_q;
  assign x_position_o = ox_q;
  assign y_position_o = oy_q;
  assign heading_o    = oh_q;

endmodule

>>> rtl/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// Signed multiplier, radix-16 digit serial: one 4-bit digit of b per cycle.
// ----------------------------------------------------------------------------
module ddo_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddo_pkg::mul_req_t  req_i,
  output logic               done_o,
  output logic signed [67:0] prod_o
);

  logic [33:0] mcand_q;
  logic [37:0] hi_q;
  logic [35:0] lo_q;
  logic        neg_q;
  logic        busy_q;
  logic        done_q;
  logic [3:0]  cnt_q;

  logic [33:0] a_mag;
  logic [33:0] b_mag;
  logic [37:0] pp;
  logic [37:0] sum;
  logic [73:0] full;

  assign a_mag = req_i.a[33] ? 34'(-req_i.a) : 34'(req_i.a);
  assign b_mag = req_i.b[33] ? 34'(-req_i.b) : 34'(req_i.b);
  assign pp    = mcand_q * lo_q[3:0];
  assign sum   = hi_q + pp;
  assign full  = {hi_q, lo_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 4'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 4'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 4'd1;
        if (cnt_q == 4'd8) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mcand_q <= a_mag;
      hi_q    <= '0;
      lo_q    <= {2'b00, b_mag};
      neg_q   <= req_i.a[33] ^ req_i.b[33];
    end else if (busy_q) begin
      hi_q <= {4'b0000, sum[37:4]};
      lo_q <= {sum[3:0], lo_q[35:4]};
    end
  end

  assign done_o = done_q;
  assign prod_o = neg_q ? -$signed(full[67:0]) : $signed(full[67:0]);

endmodule

>>> rtl/ddo_div.sv
// ----------------------------------------------------------------------------
// ddo_div
// Radix-2 restoring divider: trunc(num * 2^30 / den), one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ddo_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddo_pkg::div_req_t  req_i,
  output logic               done_o,
  output logic signed [32:0] quot_o
);

  logic [36:0] rem_q;
  logic [31:0] lo_q;
  logic [36:0] d_q;
  logic        neg_q;
  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;

  logic [33:0] n_mag;
  logic [37:0] d_mag;
  logic [37:0] t;
  logic [37:0] diff;
  logic        ge;

  assign n_mag = req_i.num[33] ? 34'(-req_i.num) : 34'(req_i.num);
  assign d_mag = req_i.den[37] ? 38'(-req_i.den) : 38'(req_i.den);
  assign t     = {rem_q, lo_q[31]};
  assign ge    = t >= {1'b0, d_q};
  assign diff  = t - {1'b0, d_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // remainder starts with the dividend bits above the 32 quotient bits
  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= {5'b00000, n_mag[33:2]};
      lo_q  <= {n_mag[1:0], 30'd0};
      d_q   <= d_mag[36:0];
      neg_q <= req_i.num[33] ^ req_i.den[37];
    end else if (busy_q) begin
      rem_q <= ge ? diff[36:0] : t[36:0];
      lo_q  <= {lo_q[30:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? -$signed({1'b0, lo_q}) : $signed({1'b0, lo_q});

endmodule

>>> rtl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Sine and cosine of a Q30 angle: range reduction, then 30 CORDIC rotations.
// ----------------------------------------------------------------------------
module ddo_cordic (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  ddo_pkg::cor_req_t  req_i,
  output logic               done_o,
  output logic signed [33:0] sin_o,
  output logic signed [33:0] cos_o
);

  localparam logic [1:0] C_IDLE = 2'd0;
  localparam logic [1:0] C_RED  = 2'd1;
  localparam logic [1:0] C_PREP = 2'd2;
  localparam logic [1:0] C_ROT  = 2'd3;

  localparam logic [37:0] TP_U = 38'(ddo_pkg::TWO_PI_Q30);

  logic [1:0]         state_q;
  logic               done_q;
  logic [2:0]         k_q;
  logic [4:0]         i_q;
  logic [37:0]        red_q;
  logic signed [33:0] x_q;
  logic signed [33:0] y_q;
  logic signed [33:0] z_q;
  logic               flip_q;

  logic signed [39:0] biased;
  logic [37:0]        tpk;
  logic signed [34:0] zr;
  logic signed [34:0] z0;
  logic signed [34:0] z1;
  logic               flip;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;

  assign biased = 40'(req_i.angle) + (ddo_pkg::TWO_PI_Q30 <<< 4);
  assign tpk    = TP_U << k_q;
  assign zr     = $signed({2'b00, red_q[32:0]});
  assign z0     = (zr > ddo_pkg::PI_Q30) ? zr - 35'(ddo_pkg::TWO_PI_Q30) : zr;
  assign xs     = x_q >>> i_q;
  assign ys     = y_q >>> i_q;
  assign at     = $signed({4'b0000, ddo_pkg::atan_q30(i_q)});

  // fold into the right half plane
  always_comb begin
    flip = 1'b0;
    z1   = z0;
    if (z0 > ddo_pkg::HALF_PI_Q30) begin
      z1   = ddo_pkg::PI_Q30 - z0;
      flip = 1'b1;
    end else if (z0 < -ddo_pkg::HALF_PI_Q30) begin
      z1   = -ddo_pkg::PI_Q30 - z0;
      flip = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      done_q  <= 1'b0;
      k_q     <= 3'd0;
      i_q     <= 5'd0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        C_IDLE: begin
          if (req_i.start) begin
            state_q <= C_RED;
            k_q     <= 3'd4;
          end
        end
        C_RED: begin
          if (k_q == 3'd0) begin
            state_q <= C_PREP;
          end else begin
            k_q <= k_q - 3'd1;
          end
        end
        C_PREP: begin
          state_q <= C_ROT;
          i_q     <= 5'd0;
        end
        C_ROT: begin
          if (i_q == ddo_pkg::CORDIC_LAST) begin
            state_q <= C_IDLE;
            done_q  <= 1'b1;
          end else begin
            i_q <= i_q + 5'd1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      C_IDLE: begin
        if (req_i.start) begin
          red_q <= biased[37:0];
        end
      end
      C_RED: begin
        if (red_q >= tpk) begin
          red_q <= red_q - tpk;
        end
      end
      C_PREP: begin
        x_q    <= ddo_pkg::CORDIC_GAIN;
        y_q    <= '0;
        z_q    <= z1[33:0];
        flip_q <= flip;
      end
      C_ROT: begin
        if (!z_q[33]) begin
          x_q <= x_q - ys;
          y_q <= y_q + xs;
          z_q <= z_q - at;
        end else begin
          x_q <= x_q + ys;
          y_q <= y_q - xs;
          z_q <= z_q + at;
        end
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign sin_o  = y_q;
  assign cos_o  = flip_q ? -x_q : x_q;

endmodule
